>>> rtl/tts_pkg.sv
// Shared types, constants and functions for the tick tone sequencer.
// Depends on nothing; used by tts_seq and tick_tone_sequencer_core.
package tts_pkg;

  // Frequency width default and the width of the frequencies held in the note ROM.
  localparam int FREQ_WIDTH_DEF = 12;
  localparam int ROM_FREQ_W     = 10;

  // Track codes.
  localparam logic [2:0] TRK_DEATH = 3'd2;
  localparam logic [2:0] TRK_WIN   = 3'd3;
  localparam logic [2:0] TRK_NONE  = 3'd7;

  // Sequence lengths in notes.
  localparam logic [2:0] DEATH_LEN = 3'd4;
  localparam logic [2:0] WIN_LEN   = 3'd5;

  // Marker for "no duty seen yet".
  localparam logic [4:0] DUTY_NONE = 5'd31;

  localparam logic [6:0] VOL_MAX = 7'd100;

  typedef struct packed {
    logic [ROM_FREQ_W-1:0] freq;
    logic [4:0]            dur;
  } note_t;

  // Status of one tick's result, apart from the frequency.
  typedef struct packed {
    logic       tone_enable;
    logic [4:0] tone_duty;
    logic       sequence_active;
  } tts_status_t;

  // Saturate the volume at 100 and divide by five. The reciprocal 205/1024
  // is exact for every value below 1024.
  function automatic logic [4:0] duty_from_volume(input logic [6:0] vol);
    logic [6:0]  v;
    logic [14:0] p;
    v = (vol > VOL_MAX) ? VOL_MAX : vol;
    p = 15'(v) * 15'd205;
    return p[14:10];
  endfunction

  // Note ROM for both one-shot sequences.
  function automatic note_t rom_note(input logic is_win, input logic [2:0] pos);
    note_t n;
    case ({is_win, pos})
      4'b0_000: n = '{freq: 10'd460, dur: 5'd1};
      4'b0_001: n = '{freq: 10'd300, dur: 5'd2};
      4'b0_010: n = '{freq: 10'd220, dur: 5'd5};
      4'b0_011: n = '{freq: 10'd0,   dur: 5'd6};
      4'b1_000: n = '{freq: 10'd440, dur: 5'd8};
      4'b1_001: n = '{freq: 10'd523, dur: 5'd8};
      4'b1_010: n = '{freq: 10'd659, dur: 5'd8};
      4'b1_011: n = '{freq: 10'd880, dur: 5'd16};
      4'b1_100: n = '{freq: 10'd0,   dur: 5'd14};
      default:  n = '{freq: 10'd0,   dur: 5'd0};
    endcase
    return n;
  endfunction

endpackage

>>> rtl/tts_seq.sv
// Sequencer state and the per-tick update that produces one buzzer result.
// Depends on tts_pkg.
module tts_seq #(
  parameter int FREQ_WIDTH = tts_pkg::FREQ_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  logic [2:0]              track,
  input  logic [6:0]              volume,
  output tts_pkg::tts_status_t    res_status,
  output logic [FREQ_WIDTH-1:0]   res_freq
);

  logic [2:0]            active_track_r, active_track_nxt;
  logic [2:0]            note_pos_r, note_pos_nxt;
  logic [4:0]            ticks_r, ticks_nxt;
  logic                  running_r, running_nxt;
  logic [FREQ_WIDTH-1:0] cur_freq_r, cur_freq_nxt;
  logic [4:0]            last_duty_r, last_duty_nxt;
  logic                  drv_on_r, drv_on_nxt;
  logic [FREQ_WIDTH-1:0] drv_freq_r, drv_freq_nxt;
  logic [4:0]            drv_duty_r, drv_duty_nxt;

  logic [4:0]            duty;
  logic                  is_win;
  logic                  is_tab;
  logic [2:0]            seq_len;
  logic [4:0]            ticks_dec;
  logic [2:0]            pos_inc;
  logic [2:0]            start_pos;
  tts_pkg::note_t        note;
  logic [FREQ_WIDTH-1:0] note_freq;
  logic                  do_start;

  assign duty    = tts_pkg::duty_from_volume(volume);
  assign is_win  = (track == tts_pkg::TRK_WIN);
  assign is_tab  = (track == tts_pkg::TRK_DEATH) || is_win;
  assign seq_len = is_win ? tts_pkg::WIN_LEN : tts_pkg::DEATH_LEN;
  assign ticks_dec = (ticks_r != 5'd0) ? (ticks_r - 5'd1) : 5'd0;
  assign pos_inc   = note_pos_r + 3'd1;
  assign start_pos = (track != active_track_r) ? 3'd0 : pos_inc;
  assign note      = tts_pkg::rom_note(is_win, start_pos);
  assign note_freq = FREQ_WIDTH'(note.freq);

  always_comb begin
    active_track_nxt = active_track_r;
    note_pos_nxt     = note_pos_r;
    ticks_nxt        = ticks_r;
    running_nxt      = running_r;
    cur_freq_nxt     = cur_freq_r;
    last_duty_nxt    = last_duty_r;
    drv_on_nxt       = drv_on_r;
    drv_freq_nxt     = drv_freq_r;
    drv_duty_nxt     = drv_duty_r;
    do_start         = 1'b0;

    if (!is_tab) begin
      drv_on_nxt   = 1'b0;
      drv_freq_nxt = '0;
      drv_duty_nxt = '0;
    end else if (track != active_track_r) begin
      active_track_nxt = track;
      note_pos_nxt     = 3'd0;
      running_nxt      = 1'b1;
      do_start         = 1'b1;
    end else if (!running_r) begin
      if (duty == 5'd0) begin
        drv_on_nxt   = 1'b0;
        drv_freq_nxt = '0;
        drv_duty_nxt = '0;
      end
    end else begin
      // A volume change inside a note only touches the duty.
      if (duty != last_duty_r) begin
        last_duty_nxt = duty;
        if (duty == 5'd0) begin
          drv_on_nxt   = 1'b0;
          drv_freq_nxt = '0;
          drv_duty_nxt = '0;
        end else if (cur_freq_r != '0) begin
          drv_on_nxt   = 1'b1;
          drv_freq_nxt = cur_freq_r;
          drv_duty_nxt = duty;
        end
      end
      ticks_nxt = ticks_dec;
      if (ticks_dec == 5'd0) begin
        if (pos_inc >= seq_len) begin
          // End of the one-shot: go quiet and keep the track remembered.
          note_pos_nxt = seq_len - 3'd1;
          running_nxt  = 1'b0;
          drv_on_nxt   = 1'b0;
          drv_freq_nxt = '0;
          drv_duty_nxt = '0;
        end else begin
          note_pos_nxt = pos_inc;
          do_start     = 1'b1;
        end
      end
    end

    if (do_start) begin
      cur_freq_nxt  = note_freq;
      last_duty_nxt = duty;
      ticks_nxt     = note.dur;
      if ((note_freq == '0) || (duty == 5'd0)) begin
        drv_on_nxt   = 1'b0;
        drv_freq_nxt = '0;
        drv_duty_nxt = '0;
      end else begin
        drv_on_nxt   = 1'b1;
        drv_freq_nxt = note_freq;
        drv_duty_nxt = duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_track_r <= tts_pkg::TRK_NONE;
      note_pos_r     <= 3'd0;
      ticks_r        <= 5'd0;
      running_r      <= 1'b0;
      cur_freq_r     <= '0;
      last_duty_r    <= tts_pkg::DUTY_NONE;
      drv_on_r       <= 1'b0;
      drv_freq_r     <= '0;
      drv_duty_r     <= 5'd0;
    end else if (step_en) begin
      active_track_r <= active_track_nxt;
      note_pos_r     <= note_pos_nxt;
      ticks_r        <= ticks_nxt;
      running_r      <= running_nxt;
      cur_freq_r     <= cur_freq_nxt;
      last_duty_r    <= last_duty_nxt;
      drv_on_r       <= drv_on_nxt;
      drv_freq_r     <= drv_freq_nxt;
      drv_duty_r     <= drv_duty_nxt;
    end
  end

  // The result reflects the state after this tick.
  assign res_status.tone_enable     = drv_on_nxt;
  assign res_status.tone_duty       = drv_on_nxt ? drv_duty_nxt : 5'd0;
  assign res_status.sequence_active = running_nxt;
  assign res_freq                   = drv_on_nxt ? drv_freq_nxt : '0;

endmodule

>>> rtl/tick_tone_sequencer_core.sv
// Top level of the tick tone sequencer: request handshakes and result buffering.
// Depends on tts_pkg and tts_seq.
//
// Each input request is one tick carrying a track number and a volume, and
// produces exactly one result request with the buzzer drive for that tick.
// Tracks 2 (death) and 3 (win) play one-shot note sequences from an internal
// ROM; selecting a different table track restarts its sequence, while any
// other track silences the buzzer without disturbing the sequence state.
// After the last note the buzzer stays silent until the track changes. The
// volume saturates at 100 and the duty is volume divided by five. The block
// takes one tick per clock cycle while in_stall is low: the whole sequencer
// update is a single combinational pass from the state registers into the
// result register, which takes the result at the accepting edge unless it
// still holds an untaken one. A one-entry skid buffer behind the result
// register lets the block keep accepting while a result waits; in_stall
// rises only when both the result register and the skid buffer are full.
// There are no configuration registers and no clearing pass after reset.
module tick_tone_sequencer_core #(
  parameter int FREQ_WIDTH = tts_pkg::FREQ_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [2:0]            in_track_select,
  input  logic [6:0]            in_volume_level,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_tone_enable,
  output logic [FREQ_WIDTH-1:0] out_tone_frequency,
  output logic [4:0]            out_tone_duty,
  output logic                  out_sequence_active
);

  logic                  in_take;
  logic                  out_take;
  logic                  out_free;

  tts_pkg::tts_status_t  res_status;
  logic [FREQ_WIDTH-1:0] res_freq;

  logic                  out_valid_r;
  tts_pkg::tts_status_t  out_status_r;
  logic [FREQ_WIDTH-1:0] out_freq_r;

  logic                  skid_valid_r;
  tts_pkg::tts_status_t  skid_status_r;
  logic [FREQ_WIDTH-1:0] skid_freq_r;

  // The sequencer state advances only on an accepted tick.
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;
  // The result register can be loaded when it is empty or being emptied.
  assign out_free = !out_valid_r || out_take;

  tts_seq #(
    .FREQ_WIDTH (FREQ_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (in_take),
    .track      (in_track_select),
    .volume     (in_volume_level),
    .res_status (res_status),
    .res_freq   (res_freq)
  );

  // Control: valid flags of the result register and the skid buffer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_take;
      end
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: the skid entry drains first so results stay in order.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_status_r <= skid_status_r;
        out_freq_r   <= skid_freq_r;
      end else if (in_take) begin
        out_status_r <= res_status;
        out_freq_r   <= res_freq;
      end
    end else if (in_take) begin
      skid_status_r <= res_status;
      skid_freq_r   <= res_freq;
    end
  end

  assign in_stall            = skid_valid_r;
  assign out_valid           = out_valid_r;
  assign out_tone_enable     = out_status_r.tone_enable;
  assign out_tone_frequency  = out_freq_r;
  assign out_tone_duty       = out_status_r.tone_duty;
  assign out_sequence_active = out_status_r.sequence_active;

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for tick_tone_sequencer_core: directed and random ticks.
// Depends on tts_pkg for the track codes, the sequence lengths and the duty markers.

// One tick's buzzer drive, as the result channel reports it.
typedef struct packed {
  logic        enable;
  logic [11:0] freq;
  logic [4:0]  duty;
  logic        active;
} buzz_drive_t;

// Tone predictor plus the queue of buzzer drives still owed by the block.
class tone_scoreboard;
  bit [2:0]  cur_track;
  bit [2:0]  note_idx;
  bit [4:0]  ticks_left;
  bit        playing;
  bit [11:0] note_freq;
  bit [4:0]  held_duty;
  bit        buzz_on;
  bit [11:0] buzz_freq;
  bit [4:0]  buzz_duty;
  int        mismatches;
  buzz_drive_t owed[$];

  bit [11:0] death_hz  [4] = '{12'd460, 12'd300, 12'd220, 12'd0};
  bit [4:0]  death_dur [4] = '{5'd1, 5'd2, 5'd5, 5'd6};
  bit [11:0] win_hz    [5] = '{12'd440, 12'd523, 12'd659, 12'd880, 12'd0};
  bit [4:0]  win_dur   [5] = '{5'd8, 5'd8, 5'd8, 5'd16, 5'd14};

  function new();
    cur_track  = tts_pkg::TRK_NONE;
    note_idx   = 0;
    ticks_left = 0;
    playing    = 0;
    note_freq  = 0;
    held_duty  = tts_pkg::DUTY_NONE;
    silence();
    mismatches = 0;
  endfunction

  function void silence();
    buzz_on   = 0;
    buzz_freq = 0;
    buzz_duty = 0;
  endfunction

  function void sound(bit [11:0] f, bit [4:0] d);
    buzz_on   = 1;
    buzz_freq = f;
    buzz_duty = d;
  endfunction

  function void begin_note(bit [4:0] duty);
    if (cur_track == tts_pkg::TRK_WIN) begin
      note_freq  = win_hz[note_idx];
      ticks_left = win_dur[note_idx];
    end else begin
      note_freq  = death_hz[note_idx];
      ticks_left = death_dur[note_idx];
    end
    held_duty = duty;
    if (note_freq == 0 || duty == 0) silence();
    else sound(note_freq, duty);
  endfunction

  // Advance the sequencer by one accepted tick and queue the drive it causes.
  function void note_tick(bit [2:0] trk, bit [6:0] vol);
    bit [6:0]    v;
    bit [4:0]    duty;
    int          seq_len;
    buzz_drive_t d;
    v    = (vol > tts_pkg::VOL_MAX) ? tts_pkg::VOL_MAX : vol;
    duty = 5'(v / 7'd5);
    seq_len = (trk == tts_pkg::TRK_WIN) ? int'(tts_pkg::WIN_LEN) : int'(tts_pkg::DEATH_LEN);
    if (trk != tts_pkg::TRK_DEATH && trk != tts_pkg::TRK_WIN) begin
      silence();
    end else if (trk != cur_track) begin
      cur_track = trk;
      note_idx  = 0;
      playing   = 1;
      begin_note(duty);
    end else if (!playing) begin
      if (duty == 0) silence();
    end else begin
      if (duty != held_duty) begin
        held_duty = duty;
        if (duty == 0) silence();
        else if (note_freq != 0) sound(note_freq, duty);
      end
      if (ticks_left > 0) ticks_left--;
      if (ticks_left == 0) begin
        if (int'(note_idx) + 1 >= seq_len) begin
          playing = 0;
          silence();
        end else begin
          note_idx++;
          begin_note(duty);
        end
      end
    end
    d.enable = buzz_on;
    d.freq   = buzz_on ? buzz_freq : 12'd0;
    d.duty   = buzz_on ? buzz_duty : 5'd0;
    d.active = playing;
    owed.push_back(d);
  endfunction

  function void check_drive(buzz_drive_t got);
    buzz_drive_t want;
    if (owed.size() == 0) begin
      $error("result with no request outstanding: enable %0d freq %0d duty %0d active %0d",
             got.enable, got.freq, got.duty, got.active);
      mismatches++;
      return;
    end
    want = owed.pop_front();
    if (got.enable !== want.enable) begin
      $error("tone_enable: expected %0d, actual %0d", want.enable, got.enable);
      mismatches++;
    end
    if (got.freq !== want.freq) begin
      $error("tone_frequency: expected %0d, actual %0d", want.freq, got.freq);
      mismatches++;
    end
    if (got.duty !== want.duty) begin
      $error("tone_duty: expected %0d, actual %0d", want.duty, got.duty);
      mismatches++;
    end
    if (got.active !== want.active) begin
      $error("sequence_active: expected %0d, actual %0d", want.active, got.active);
      mismatches++;
    end
  endfunction

  function int pending();
    return owed.size();
  endfunction
endclass

module tb;
  // Tracks that carry no note table. The block must silence the buzzer on
  // any of them and leave the sequence state alone.
  localparam logic [2:0] TRK_TITLE = 3'd0;
  localparam logic [2:0] TRK_PLAY  = 3'd1;
  localparam logic [2:0] TRK_SPARE = 3'd5;

  // Minimum number of ticks to send, and the number of consecutive cycles
  // without any handshake on either channel that we treat as a hang.
  localparam int TICK_TARGET = 1900;
  localparam int HANG_LIMIT  = 2000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_track_select;
  logic [6:0]  in_volume_level;
  logic        out_valid;
  logic        out_stall;
  logic        out_tone_enable;
  logic [tts_pkg::FREQ_WIDTH_DEF-1:0] out_tone_frequency;
  logic [4:0]  out_tone_duty;
  logic        out_sequence_active;

  tone_scoreboard sb;
  int ticks_sent;
  // When set, neither side inserts idle cycles, so back-to-back traffic is
  // exercised in stretches.
  bit calm;
  int idle_cycles;

  tick_tone_sequencer_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_track_select     (in_track_select),
    .in_volume_level     (in_volume_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_tone_enable     (out_tone_enable),
    .out_tone_frequency  (out_tone_frequency),
    .out_tone_duty       (out_tone_duty),
    .out_sequence_active (out_sequence_active)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Per-request wait, drawn at random. Zero is favored so that the block also
  // sees long runs of consecutive requests; calm phases never wait.
  function automatic int draw_wait();
    if (calm) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Volumes are biased toward the duty-zero range and the saturation range,
  // since those are where the sequencer changes its behavior.
  function automatic logic [6:0] draw_volume();
    case ($urandom_range(0, 3))
      0:       return 7'($urandom_range(0, 9));
      1:       return 7'($urandom_range(95, 127));
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic logic [2:0] draw_silent_track();
    logic [2:0] t;
    t = 3'($urandom_range(0, 7));
    while (t == tts_pkg::TRK_DEATH || t == tts_pkg::TRK_WIN) t = 3'($urandom_range(0, 7));
    return t;
  endfunction

  // Send one tick request. Called right after a rising edge; returns right
  // after the edge at which the request was accepted. With a zero wait the
  // valid stays high, so it is never dropped and raised in one time step.
  task automatic send_tick(input logic [2:0] trk, input logic [6:0] vol);
    int wait_cycles;
    wait_cycles = draw_wait();
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_track_select <= trk;
    in_volume_level <= vol;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_tick(trk, vol);
    ticks_sent++;
  endtask

  // Hold off the sender until the block has delivered every result owed.
  // The loop waits on the clock before checking, so valid is not lowered and raised in one step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // A well-formed play: usually force a restart by touching the other table
  // track first, then keep one table track selected for a random stretch
  // with mostly steady volume and an occasional silent-track interruption.
  task automatic play_sequence();
    logic [2:0] trk;
    logic [2:0] other;
    logic [6:0] vol;
    int         span;
    trk   = $urandom_range(0, 1) ? tts_pkg::TRK_WIN : tts_pkg::TRK_DEATH;
    other = (trk == tts_pkg::TRK_WIN) ? tts_pkg::TRK_DEATH : tts_pkg::TRK_WIN;
    span  = (trk == tts_pkg::TRK_WIN) ? $urandom_range(1, 64) : $urandom_range(1, 20);
    vol   = draw_volume();
    if ($urandom_range(0, 3) != 0) send_tick(other, draw_volume());
    repeat (span) begin
      if ($urandom_range(0, 9) == 0) vol = draw_volume();
      if ($urandom_range(0, 19) == 0) send_tick(draw_silent_track(), vol);
      else send_tick(trk, vol);
    end
  endtask

  // Result side: stall for a drawn number of cycles, then take one result.
  initial begin
    buzz_drive_t got;
    int          stall_cycles;
    out_stall = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall_cycles = draw_wait();
      if (stall_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (stall_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.enable = out_tone_enable;
      got.freq   = out_tone_frequency;
      got.duty   = out_tone_duty;
      got.active = out_sequence_active;
      sb.check_drive(got);
    end
  end

  // Hang detection: count cycles in which neither channel completes a
  // request. Any correct run hands something over well within the limit.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    sb              = new();
    ticks_sent      = 0;
    calm            = 1'b0;
    idle_cycles     = 0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_track_select = TRK_TITLE;
    in_volume_level = 7'd0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Tracks without a table come first, so the buzzer must
    // stay off straight out of reset.
    send_tick(TRK_TITLE, 7'd0);
    send_tick(TRK_PLAY, 7'd127);
    // Death sequence at saturated volume: the first note lasts one tick.
    send_tick(tts_pkg::TRK_DEATH, 7'd127);
    send_tick(tts_pkg::TRK_DEATH, 7'd127);
    // A volume change inside a note only updates the duty.
    send_tick(tts_pkg::TRK_DEATH, 7'd50);
    // A silent track in the middle must not disturb the sequence, and coming
    // back to the same track must not restart it.
    send_tick(TRK_SPARE, 7'd50);
    send_tick(tts_pkg::TRK_DEATH, 7'd50);
    // Duty zero silences a sounding note; raising the volume brings it back.
    send_tick(tts_pkg::TRK_DEATH, 7'd3);
    send_tick(tts_pkg::TRK_DEATH, 7'd100);
    send_tick(tts_pkg::TRK_DEATH, 7'd101);
    send_tick(tts_pkg::TRK_DEATH, 7'd4);
    // This tick enters the trailing rest; a volume change during the rest
    // must keep the buzzer quiet.
    send_tick(tts_pkg::TRK_DEATH, 7'd4);
    send_tick(tts_pkg::TRK_DEATH, 7'd90);
    repeat (4) send_tick(tts_pkg::TRK_DEATH, 7'd90);
    // The rest runs out here and the sequence ends.
    send_tick(tts_pkg::TRK_DEATH, 7'd90);
    // A finished one-shot stays silent while the same track is held.
    send_tick(tts_pkg::TRK_DEATH, 7'd127);
    send_tick(tts_pkg::TRK_DEATH, 7'd0);
    // Win sequence starting at duty zero: running but silent, then audible.
    send_tick(tts_pkg::TRK_WIN, 7'd0);
    send_tick(tts_pkg::TRK_WIN, 7'd5);
    send_tick(tts_pkg::TRK_NONE, 7'd127);
    // Changing track restarts the death sequence from its first note.
    send_tick(tts_pkg::TRK_DEATH, 7'd127);

    // Let everything come out before the random part begins.
    drain_results();

    // Random part: mostly well-formed plays, the rest unconstrained noise,
    // with calm stretches and occasional full drains mixed in.
    while (ticks_sent < TICK_TARGET) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) < 7) begin
        play_sequence();
      end else begin
        repeat ($urandom_range(1, 20)) send_tick(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
      end
      if ($urandom_range(0, 15) == 0) drain_results();
    end
    calm = 1'b0;

    // Wait for the last results, then keep the clock running to catch any extra
    // result the block might still produce.
    drain_results();
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
